// ===== sv/alc_pkg.sv =====
// Shared types and constants of the alpha layer compositor.
// No dependencies; used by alc_ctrl, alc_datapath and alpha_layer_compositor.
package alc_pkg;

  localparam int unsigned COL_W   = 24;  // signed Q7.16 colour
  localparam int unsigned ALPHA_W = 17;  // unsigned Q1.16 opacity
  localparam int unsigned NUM_CH  = 3;   // X, Y, Z
  localparam int unsigned TDATA_W = 96;  // 3*24 + 17 = 89 bits, padded to bytes

  localparam int unsigned MAX_LAYERS_DEF = 16;

  // Restoring divider: one quotient bit per cycle over the alpha width
  localparam int unsigned DIV_STEPS = ALPHA_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic [ALPHA_W-1:0] ONE_Q16 = ALPHA_W'(65536);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL1,
    ST_MUL2,
    ST_UPD
  } alc_state_e;

  typedef struct packed {
    logic accept;    // capture input request, advance position
    logic div_step;  // one restoring divide step on the layer alpha
    logic mul1;      // first product rank
    logic mul2;      // second product rank
    logic update;    // write accumulator and, on last layer, the result
  } alc_cmd_t;

  typedef struct packed {
    logic avg;       // averaging mode
    logic first;     // captured layer is a bottom layer
    logic last;      // captured layer is a top layer
    logic out_busy;  // result register full and not taken this cycle
  } alc_sts_t;

endpackage

// ===== sv/alc_ctrl.sv =====
// Sequencer of the alpha layer compositor: accept, divide, multiply, update.
// Depends on alc_pkg; drives alc_datapath through alc_cmd_t.
module alc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_first_i,
  input  alc_pkg::alc_sts_t sts_i,
  output logic              in_ready_o,
  output alc_pkg::alc_cmd_t cmd_o
);

  alc_pkg::alc_state_e state_q, state_d;
  logic [alc_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic upd_stall;

  assign upd_stall = sts_i.last && sts_i.out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= alc_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      alc_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          if (in_first_i) begin
            state_d = alc_pkg::ST_UPD;
          end else if (sts_i.avg) begin
            state_d = alc_pkg::ST_DIV;
          end else begin
            state_d = alc_pkg::ST_MUL1;
          end
        end
      end
      alc_pkg::ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == alc_pkg::CNT_W'(alc_pkg::DIV_STEPS - 1)) begin
          state_d = alc_pkg::ST_MUL1;
        end
      end
      alc_pkg::ST_MUL1: state_d = alc_pkg::ST_MUL2;
      alc_pkg::ST_MUL2: state_d = alc_pkg::ST_UPD;
      alc_pkg::ST_UPD: begin
        // hold a top layer while the previous pixel still sits in the result register
        if (!upd_stall) begin
          state_d = alc_pkg::ST_IDLE;
        end
      end
      default: state_d = alc_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      alc_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      alc_pkg::ST_DIV:  cmd_o.div_step = 1'b1;
      alc_pkg::ST_MUL1: cmd_o.mul1     = 1'b1;
      alc_pkg::ST_MUL2: cmd_o.mul2     = 1'b1;
      alc_pkg::ST_UPD:  cmd_o.update   = !upd_stall;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== sv/alc_datapath.sv =====
// Datapath of the alpha layer compositor: layer capture, alpha divider,
// product ranks, accumulator and result register. Depends on alc_pkg.
module alc_datapath #(
  parameter int unsigned MAX_LAYERS = alc_pkg::MAX_LAYERS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic [alc_pkg::TDATA_W-1:0] in_data_i,
  input  logic                        in_first_i,
  input  logic                        in_last_i,
  input  alc_pkg::alc_cmd_t           cmd_i,
  output alc_pkg::alc_sts_t           sts_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [alc_pkg::TDATA_W-1:0] out_data_o
);

  localparam int unsigned CW  = alc_pkg::COL_W;
  localparam int unsigned AW  = alc_pkg::ALPHA_W;
  localparam int unsigned NC  = alc_pkg::NUM_CH;
  localparam int unsigned PW  = $clog2(MAX_LAYERS + 1);
  localparam int unsigned P1W = CW + AW + 1;        // colour * alpha
  localparam int unsigned P2W = CW + AW + 1;        // new colour * a2
  localparam int unsigned QW  = P1W + AW + 1;       // colour * alpha * inv
  localparam int unsigned SW  = QW + 1;             // rounded sum
  localparam int unsigned RW  = SW - 32;            // after the scale-down
  localparam int unsigned PAW = 2 * AW;             // alpha * inv
  localparam int unsigned NAW = PAW + 1;
  localparam int unsigned DATA_BITS = NC * CW + AW;

  localparam logic signed [SW-1:0] COL_RND   = SW'(64'sd2147483648);
  localparam logic [NAW-1:0]       ALPHA_RND = NAW'(32768);

  logic avg_q;
  logic lay_first_q, lay_last_q;
  logic signed [CW-1:0] lay_c_q [NC];
  logic [AW-1:0] a2_q;
  logic [PW-1:0] rem_q;
  logic [PW-1:0] pos_q;

  logic signed [CW-1:0]  acc_c_q [NC];
  logic [AW-1:0]         acc_alpha_q;
  logic signed [P1W-1:0] p1_q [NC];
  logic signed [P2W-1:0] p2_q [NC];
  logic signed [QW-1:0]  q_q  [NC];
  logic [PAW-1:0]        pa_q;

  logic                  out_valid_q;
  logic signed [CW-1:0]  out_c_q [NC];
  logic [AW-1:0]         out_alpha_q;

  logic [AW-1:0]         in_alpha, in_alpha_sat, inv;
  logic [PW:0]           rem_sh;
  logic                  div_ge;
  logic signed [SW-1:0]  sum   [NC];
  logic signed [RW-1:0]  rsum  [NC];
  logic signed [CW-1:0]  new_c [NC];
  logic [NAW-1:0]        na_sum;
  logic [NAW-17:0]       na_shr;
  logic [AW-1:0]         new_alpha;

  assign in_alpha     = in_data_i[NC*CW +: AW];
  assign in_alpha_sat = (in_alpha > alc_pkg::ONE_Q16) ? alc_pkg::ONE_Q16 : in_alpha;
  assign inv          = alc_pkg::ONE_Q16 - a2_q;

  // Restoring divide step: shift the next dividend bit into the remainder
  assign rem_sh = {rem_q, a2_q[AW-1]};
  assign div_ge = rem_sh >= {1'b0, pos_q};

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      sum[i]  = SW'(q_q[i]) + (SW'(p2_q[i]) <<< 16) + COL_RND;
      rsum[i] = sum[i][SW-1:32];
      // saturate when the bits above the colour width are not a sign copy
      if (rsum[i][RW-1:CW-1] == {(RW-CW+1){rsum[i][RW-1]}}) begin
        new_c[i] = rsum[i][CW-1:0];
      end else begin
        new_c[i] = rsum[i][RW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end
    end
    na_sum    = NAW'(pa_q) + {a2_q, 16'h0000} + ALPHA_RND;
    na_shr    = na_sum[NAW-1:16];
    new_alpha = (na_shr > (NAW-16)'(alc_pkg::ONE_Q16)) ? alc_pkg::ONE_Q16 : na_shr[AW-1:0];
  end

  // Control and accumulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q       <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      acc_alpha_q <= '0;
      for (int i = 0; i < NC; i++) begin
        acc_c_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        avg_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        if (in_first_i) begin
          pos_q <= PW'(1);
        end else if (pos_q < PW'(MAX_LAYERS)) begin
          pos_q <= pos_q + 1'b1;
        end
      end
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.update) begin
        if (lay_first_q) begin
          acc_alpha_q <= a2_q;
          for (int i = 0; i < NC; i++) begin
            acc_c_q[i] <= lay_c_q[i];
          end
        end else begin
          acc_alpha_q <= new_alpha;
          for (int i = 0; i < NC; i++) begin
            acc_c_q[i] <= new_c[i];
          end
        end
        if (lay_last_q) begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      lay_first_q <= in_first_i;
      lay_last_q  <= in_last_i;
      a2_q        <= in_alpha_sat;
      rem_q       <= '0;
      for (int i = 0; i < NC; i++) begin
        lay_c_q[i] <= in_data_i[i*CW +: CW];
      end
    end
    if (cmd_i.div_step) begin
      a2_q  <= {a2_q[AW-2:0], div_ge};
      rem_q <= div_ge ? PW'(rem_sh - {1'b0, pos_q}) : rem_sh[PW-1:0];
    end
    if (cmd_i.mul1) begin
      pa_q <= acc_alpha_q * inv;
      for (int i = 0; i < NC; i++) begin
        p1_q[i] <= acc_c_q[i] * $signed({1'b0, acc_alpha_q});
        p2_q[i] <= lay_c_q[i] * $signed({1'b0, a2_q});
      end
    end
    if (cmd_i.mul2) begin
      for (int i = 0; i < NC; i++) begin
        q_q[i] <= p1_q[i] * $signed({1'b0, inv});
      end
    end
    if (cmd_i.update && lay_last_q) begin
      if (lay_first_q) begin
        out_alpha_q <= a2_q;
        for (int i = 0; i < NC; i++) begin
          out_c_q[i] <= lay_c_q[i];
        end
      end else begin
        out_alpha_q <= new_alpha;
        for (int i = 0; i < NC; i++) begin
          out_c_q[i] <= new_c[i];
        end
      end
    end
  end

  always_comb begin
    sts_o          = '0;
    sts_o.avg      = avg_q;
    sts_o.first    = lay_first_q;
    sts_o.last     = lay_last_q;
    sts_o.out_busy = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {{(alc_pkg::TDATA_W - DATA_BITS){1'b0}}, out_alpha_q,
                        out_c_q[2], out_c_q[1], out_c_q[0]};

endmodule

// ===== sv/alpha_layer_compositor.sv =====
// Alpha layer compositor: stacks the layers of a pixel with the over operator.
// Depends on alc_pkg, alc_ctrl and alc_datapath.
//
// Layers arrive bottom first, one per request; tuser marks the bottom layer
// and tlast the top layer, which produces one composite on the master side.
// A bottom layer goes straight from accept to update; every other layer
// passes two product ranks and an accumulate, in averaging mode after a
// restoring divider works out alpha / position one quotient bit per cycle.
// A top layer waits in its update step while an earlier composite still
// sits unread in the result register. Colour saturates to signed Q7.16,
// alpha to 1.0, and the layer position stops counting at MAX_LAYERS.
module alpha_layer_compositor #(
  parameter int unsigned MAX_LAYERS = alc_pkg::MAX_LAYERS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,    // average_mode
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // layer_x[23:0], layer_y[47:24], layer_z[71:48], layer_alpha[88:72], zero pad
  input  logic [alc_pkg::TDATA_W-1:0] s_axis_tdata,
  input  logic                        s_axis_tuser,   // first_layer
  input  logic                        s_axis_tlast,   // last_layer
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // out_x[23:0], out_y[47:24], out_z[71:48], out_alpha[88:72], zero pad
  output logic [alc_pkg::TDATA_W-1:0] m_axis_tdata
);

  alc_pkg::alc_cmd_t cmd;
  alc_pkg::alc_sts_t sts;

  alc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_first_i (s_axis_tuser),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  alc_datapath #(
    .MAX_LAYERS (MAX_LAYERS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_first_i  (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule
